@@ hw/rtl/dewt_pkg.sv @@
// Shared constants, types and codes of the dual encoder window tachometer.
package dewt_pkg;

    localparam int FRAC_BITS  = 4;
    localparam int TIME_W     = 32;
    localparam int TOTAL_W    = 32;
    localparam int CFG_W      = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int SPEED_W    = 24;
    localparam int PROD_W     = TOTAL_W + CFG_W;
    localparam int NUM_W      = PROD_W + FRAC_BITS;
    localparam int QUO_BITS   = SPEED_W + 1;
    localparam int DIV_W      = PROD_W + QUO_BITS - 1;
    localparam int STEP_W     = $clog2(QUO_BITS);

    localparam logic [CFG_W-1:0] MS_PER_MIN        = CFG_W'(60000);
    localparam logic [CFG_W-1:0] WINDOW_MS_RESET   = CFG_W'(100);
    localparam logic [CFG_W-1:0] TICKS_REV_RESET   = CFG_W'(20);
    localparam logic [SPEED_W-1:0] SPEED_MAX       = {SPEED_W{1'b1}};

    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_MS     = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_TICKS_PER_REV = CFG_IDX_W'(1);

    typedef enum logic [1:0] {
        OP_IDLE,
        OP_MUL,
        OP_DIV_LOAD,
        OP_DIV_STEP
    } op_t;

    typedef struct packed {
        op_t                op;
        logic [TOTAL_W-1:0] a;
        logic [CFG_W-1:0]   b;
        logic [PROD_W-1:0]  den;
    } cmd_t;

endpackage

@@ hw/rtl/dewt_if.sv @@
// Valid/ready channel interfaces for the input words and the result words.
interface dewt_in_if;
    logic                          valid;
    logic                          ready;
    logic [dewt_pkg::TIME_W-1:0]   now_ms;
    logic [dewt_pkg::TOTAL_W-1:0]  left_edges;
    logic [dewt_pkg::TOTAL_W-1:0]  right_edges;

    modport source (output valid, output now_ms, output left_edges, output right_edges,
                    input ready);
    modport sink (input valid, input now_ms, input left_edges, input right_edges,
                  output ready);
endinterface

interface dewt_out_if;
    logic                          valid;
    logic                          ready;
    logic [dewt_pkg::SPEED_W-1:0]  left_speed;
    logic [dewt_pkg::SPEED_W-1:0]  right_speed;

    modport source (output valid, output left_speed, output right_speed, input ready);
    modport sink (input valid, input left_speed, input right_speed, output ready);
endinterface

@@ hw/rtl/dewt_arith.sv @@
// Shared arithmetic unit: one 32x16 multiplier and one compare-subtract divider step.
module dewt_arith (
    input  logic                                clk,
    input  dewt_pkg::cmd_t                      cmd,
    output logic [dewt_pkg::PROD_W-1:0]         prod,
    output logic [dewt_pkg::QUO_BITS-1:0]       quo
);

    logic [dewt_pkg::PROD_W-1:0]   prod_reg;
    logic [dewt_pkg::NUM_W-1:0]    rem_reg;
    logic [dewt_pkg::DIV_W-1:0]    div_reg;
    logic [dewt_pkg::QUO_BITS-1:0] quo_reg;
    logic [dewt_pkg::DIV_W-1:0]    rem_ext;
    logic [dewt_pkg::DIV_W-1:0]    diff;
    logic                          fits;

    assign rem_ext = dewt_pkg::DIV_W'(rem_reg);
    assign diff    = rem_ext - div_reg;
    assign fits    = rem_ext >= div_reg;

    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            dewt_pkg::OP_IDLE:
            begin
            end
            dewt_pkg::OP_MUL:
            begin
                prod_reg <= dewt_pkg::PROD_W'(cmd.a) * dewt_pkg::PROD_W'(cmd.b);
            end
            dewt_pkg::OP_DIV_LOAD:
            begin
                rem_reg <= {prod_reg, {dewt_pkg::FRAC_BITS{1'b0}}};
                div_reg <= dewt_pkg::DIV_W'(cmd.den) << (dewt_pkg::QUO_BITS - 1);
                quo_reg <= '0;
            end
            dewt_pkg::OP_DIV_STEP:
            begin
                if (fits)
                begin
                    rem_reg <= diff[dewt_pkg::NUM_W-1:0];
                end
                quo_reg <= {quo_reg[dewt_pkg::QUO_BITS-2:0], fits};
                div_reg <= div_reg >> 1;
            end
            default:
            begin
            end
        endcase
    end

    assign prod = prod_reg;
    assign quo  = quo_reg;

endmodule

@@ hw/rtl/dual_encoder_window_tachometer.sv @@
// Top level of the dual encoder window tachometer with its sequencer.
//
// The input channel takes one word per time sample: the millisecond time and the running
// edge totals of both wheels. A word whose elapsed time since the window start is below
// window_ms produces nothing, and the block goes back to idle. A word that closes a window
// produces one result word with both wheel speeds in rpm, unsigned with four fractional bits,
// saturating at the field maximum. A closing word passes the check and the divisor multiply,
// then per wheel, left first, a numerator multiply, a divider load and the divider steps, and
// last the finish state: one 32x16 multiplier forms the common divisor and each wheel's
// numerator, and one compare-subtract unit produces 25 quotient bits per wheel, one bit per
// cycle. The input is not ready while a word is being worked on. The result sits in an output
// register, so the next word is accepted while a result waits; a stalled receiver only holds
// the block once the following result is finished. The configuration port writes window_ms
// (index 0) and ticks_per_rev (index 1); the user must write them only while the block is
// idle, which the block itself does not enforce. A zero ticks_per_rev counts as one.
// Reset restores window_ms to 100, ticks_per_rev to 20, clears the window start and the
// stored totals, and drops any pending result.
module dual_encoder_window_tachometer (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [dewt_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [dewt_pkg::CFG_W-1:0]       cfg_data,
    dewt_in_if.sink                          in_ch,
    dewt_out_if.source                       out_ch
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_MUL_DEN,
        ST_MUL_NUML,
        ST_LOAD_L,
        ST_STEP_L,
        ST_MUL_NUMR,
        ST_LOAD_R,
        ST_STEP_R,
        ST_FINISH
    } state_t;

    state_t                           state_reg;
    logic [dewt_pkg::CFG_W-1:0]       window_ms_reg;
    logic [dewt_pkg::CFG_W-1:0]       ticks_rev_reg;
    logic [dewt_pkg::TIME_W-1:0]      window_start_reg;
    logic [dewt_pkg::TOTAL_W-1:0]     left_prev_reg;
    logic [dewt_pkg::TOTAL_W-1:0]     right_prev_reg;
    logic [dewt_pkg::TIME_W-1:0]      now_reg;
    logic [dewt_pkg::TOTAL_W-1:0]     left_reg;
    logic [dewt_pkg::TOTAL_W-1:0]     right_reg;
    logic [dewt_pkg::TIME_W-1:0]      elapsed_reg;
    logic [dewt_pkg::TOTAL_W-1:0]     left_delta_reg;
    logic [dewt_pkg::TOTAL_W-1:0]     right_delta_reg;
    logic                             zero_reg;
    logic [dewt_pkg::PROD_W-1:0]      den_reg;
    logic [dewt_pkg::STEP_W-1:0]      step_reg;
    logic [dewt_pkg::SPEED_W-1:0]     left_res_reg;
    logic                             out_valid_reg;
    logic [dewt_pkg::SPEED_W-1:0]     left_speed_reg;
    logic [dewt_pkg::SPEED_W-1:0]     right_speed_reg;

    logic [dewt_pkg::TIME_W-1:0]      elapsed;
    logic [dewt_pkg::CFG_W-1:0]       ticks_eff;
    logic [dewt_pkg::SPEED_W-1:0]     quo_sat;
    logic                             last_step;
    logic                             out_free;
    dewt_pkg::cmd_t                   cmd;
    logic [dewt_pkg::PROD_W-1:0]      prod;
    logic [dewt_pkg::QUO_BITS-1:0]    quo;

    assign elapsed   = now_reg - window_start_reg;
    assign ticks_eff = (ticks_rev_reg == '0) ? dewt_pkg::CFG_W'(1) : ticks_rev_reg;
    assign quo_sat   = zero_reg ? '0 :
                       (quo[dewt_pkg::QUO_BITS-1] ? dewt_pkg::SPEED_MAX
                                                  : quo[dewt_pkg::SPEED_W-1:0]);
    assign last_step = step_reg == dewt_pkg::STEP_W'(dewt_pkg::QUO_BITS - 1);
    assign out_free  = !out_valid_reg || out_ch.ready;

    always_comb
    begin
        cmd.op  = dewt_pkg::OP_IDLE;
        cmd.a   = left_delta_reg;
        cmd.b   = dewt_pkg::MS_PER_MIN;
        cmd.den = den_reg;
        unique case (state_reg)
            ST_MUL_DEN:
            begin
                cmd.op = dewt_pkg::OP_MUL;
                cmd.a  = elapsed_reg;
                cmd.b  = ticks_eff;
            end
            ST_MUL_NUML:
            begin
                cmd.op = dewt_pkg::OP_MUL;
            end
            ST_MUL_NUMR:
            begin
                cmd.op = dewt_pkg::OP_MUL;
                cmd.a  = right_delta_reg;
            end
            ST_LOAD_L, ST_LOAD_R:
            begin
                cmd.op = dewt_pkg::OP_DIV_LOAD;
            end
            ST_STEP_L, ST_STEP_R:
            begin
                cmd.op = dewt_pkg::OP_DIV_STEP;
            end
            default:
            begin
                cmd.op = dewt_pkg::OP_IDLE;
            end
        endcase
    end

    dewt_arith u_arith (
        .clk  (clk),
        .cmd  (cmd),
        .prod (prod),
        .quo  (quo)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            window_ms_reg    <= dewt_pkg::WINDOW_MS_RESET;
            ticks_rev_reg    <= dewt_pkg::TICKS_REV_RESET;
            window_start_reg <= '0;
            left_prev_reg    <= '0;
            right_prev_reg   <= '0;
            out_valid_reg    <= 1'b0;
            step_reg         <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    dewt_pkg::CFG_WINDOW_MS:     window_ms_reg <= cfg_data;
                    dewt_pkg::CFG_TICKS_PER_REV: ticks_rev_reg <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end

            if (out_valid_reg && out_ch.ready && state_reg != ST_FINISH)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_ch.valid)
                    begin
                        now_reg   <= in_ch.now_ms;
                        left_reg  <= in_ch.left_edges;
                        right_reg <= in_ch.right_edges;
                        state_reg <= ST_CHECK;
                    end
                end
                ST_CHECK:
                begin
                    if (elapsed < dewt_pkg::TIME_W'(window_ms_reg))
                    begin
                        state_reg <= ST_IDLE;
                    end
                    else
                    begin
                        elapsed_reg      <= elapsed;
                        zero_reg         <= elapsed == '0;
                        left_delta_reg   <= left_reg - left_prev_reg;
                        right_delta_reg  <= right_reg - right_prev_reg;
                        left_prev_reg    <= left_reg;
                        right_prev_reg   <= right_reg;
                        window_start_reg <= now_reg;
                        state_reg        <= ST_MUL_DEN;
                    end
                end
                ST_MUL_DEN:
                begin
                    state_reg <= ST_MUL_NUML;
                end
                ST_MUL_NUML:
                begin
                    den_reg   <= prod;
                    state_reg <= ST_LOAD_L;
                end
                ST_LOAD_L:
                begin
                    step_reg  <= '0;
                    state_reg <= ST_STEP_L;
                end
                ST_STEP_L:
                begin
                    step_reg <= step_reg + 1'b1;
                    if (last_step)
                    begin
                        state_reg <= ST_MUL_NUMR;
                    end
                end
                ST_MUL_NUMR:
                begin
                    left_res_reg <= quo_sat;
                    state_reg    <= ST_LOAD_R;
                end
                ST_LOAD_R:
                begin
                    step_reg  <= '0;
                    state_reg <= ST_STEP_R;
                end
                ST_STEP_R:
                begin
                    step_reg <= step_reg + 1'b1;
                    if (last_step)
                    begin
                        state_reg <= ST_FINISH;
                    end
                end
                ST_FINISH:
                begin
                    if (out_free)
                    begin
                        out_valid_reg   <= 1'b1;
                        left_speed_reg  <= left_res_reg;
                        right_speed_reg <= quo_sat;
                        state_reg       <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign in_ch.ready        = state_reg == ST_IDLE;
    assign out_ch.valid       = out_valid_reg;
    assign out_ch.left_speed  = left_speed_reg;
    assign out_ch.right_speed = right_speed_reg;

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_ch.valid && in_ch.ready |=> !in_ch.ready)
        else $error("input ready stayed high after an accepted word");

    a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_STEP_L || state_reg == ST_STEP_R)
        |-> step_reg <= dewt_pkg::STEP_W'(dewt_pkg::QUO_BITS - 1))
        else $error("divider step count ran past the quotient width");

    a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_FINISH))
        else $error("result word raised outside the finish step");

    a_zero_elapsed: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_FINISH && zero_reg && out_free
        |=> out_ch.left_speed == '0 && out_ch.right_speed == '0)
        else $error("zero elapsed time gave a nonzero speed");

endmodule
